[rtl/core/ospr_pkg.sv]
// ---------------------------------------------------------------------------
// Overcurrent protection with retry: shared definitions
// Constants, register indexes and the per-channel state word.
// ---------------------------------------------------------------------------
package ospr_pkg;

	localparam int DEF_NUM_CHANNELS = 5;
	localparam int NUM_THR_REGS     = 5;

	localparam int CUR_W   = 12;
	localparam int DELAY_W = 16;
	localparam int RETRY_W = 3;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;

	localparam logic [IDX_W-1:0]   REG_RETRY_DELAY = 3'd5;
	localparam logic [CUR_W-1:0]   DEF_THRESHOLD   = 12'd40;
	localparam logic [DELAY_W-1:0] DEF_RETRY_DELAY = 16'd100;
	localparam logic [RETRY_W-1:0] MAX_RETRIES     = 3'd3;
	localparam logic [RETRY_W-1:0] LATCHED_COUNT   = 3'd4;
	localparam logic [STAT_W-1:0]  STAT_OFF        = 2'b00;
	localparam logic [STAT_W-1:0]  STAT_ON_OK      = 2'b01;
	localparam logic [STAT_W-1:0]  STAT_FAULT      = 2'b10;

	typedef struct packed {
		logic               fault;
		logic               handled;
		logic [DELAY_W-1:0] delay;
		logic [RETRY_W-1:0] retries;
		logic [STAT_W-1:0]  status;
	} chan_state_t;

endpackage

[rtl/core/ospr_state_mem.sv]
// ---------------------------------------------------------------------------
// Overcurrent protection with retry: channel state memory
// Registered read, valid bits that stand for the cleared reset state, and
// forwarding of the last write to a read of the same entry.
// ---------------------------------------------------------------------------
module ospr_state_mem #(
	parameter int DEPTH = ospr_pkg::DEF_NUM_CHANNELS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output ospr_pkg::chan_state_t rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  ospr_pkg::chan_state_t wr_data
);

	ospr_pkg::chan_state_t mem [DEPTH];
	ospr_pkg::chan_state_t rd_word_q;
	ospr_pkg::chan_state_t fwd_word_q;
	logic [DEPTH-1:0]      vld_q;
	logic                  rd_vld_q;
	logic [AW-1:0]         rd_addr_q;
	logic                  fwd_vld_q;
	logic [AW-1:0]         fwd_addr_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (wr_en) begin
			fwd_word_q <= wr_data;
			fwd_addr_q <= wr_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
				fwd_vld_q      <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// The last write may land on the same edge as the read; it is always
	// at least as new as the array contents seen by that read.
	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == rd_addr_q)) begin
			rd_data = fwd_word_q;
		end else if (rd_vld_q) begin
			rd_data = rd_word_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

[rtl/core/output_short_protect_retry.sv]
// ---------------------------------------------------------------------------
// Overcurrent protection with automatic retry
// Per-channel drive gating, overcurrent diagnosis and retry sequencing for a
// set of load-switch channels, with the channel state held in a memory.
//
//   channel  signals                                       direction
//   in       in_valid/in_ready, channel, switch_request,   into block
//            load_current
//   out      out_valid/out_ready, drive_on, diag_status,   out of block
//            latched_off, retries_used
//   config   wr_en, wr_index, wr_data                      into block
//
// One transaction per cycle is taken while the input is not stalled. Each
// result comes from the memory read on the accepting edge, then the update
// into the output register on the edge at which the update stage advances.
// The state memory has one read and one write port; a write on the same edge
// as a read of the same channel is forwarded, so back-to-back ticks on one
// channel need no stall. Reset clears all state at once through valid bits.
// The input stalls only while the update stage and output register are full
// and the output is not being taken.
// ---------------------------------------------------------------------------
module output_short_protect_retry #(
	parameter int NUM_CHANNELS = ospr_pkg::DEF_NUM_CHANNELS,
	parameter int CH_W = (NUM_CHANNELS > 8) ? $clog2(NUM_CHANNELS) : 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [CH_W-1:0]               channel,
	input  logic                          switch_request,
	input  logic [ospr_pkg::CUR_W-1:0]    load_current,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          drive_on,
	output logic [ospr_pkg::STAT_W-1:0]   diag_status,
	output logic                          latched_off,
	output logic [ospr_pkg::RETRY_W-1:0]  retries_used,
	input  logic                          wr_en,
	input  logic [ospr_pkg::IDX_W-1:0]    wr_index,
	input  logic [ospr_pkg::DATA_W-1:0]   wr_data
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [ospr_pkg::CUR_W-1:0]   thr_q [ospr_pkg::NUM_THR_REGS];
	logic [ospr_pkg::DELAY_W-1:0] retry_delay_q;

	logic                       vld_s1;
	logic [CH_W-1:0]            ch_s1;
	logic                       inr_s1;
	logic                       req_s1;
	logic [ospr_pkg::CUR_W-1:0] cur_s1;

	logic                         out_vld_q;
	logic                         drive_q;
	logic [ospr_pkg::STAT_W-1:0]  status_q;
	logic                         latched_q;
	logic [ospr_pkg::RETRY_W-1:0] retries_q;

	logic                  accept;
	logic                  s1_adv;
	logic                  in_range;
	logic                  mem_we;
	ospr_pkg::chan_state_t cur_state;
	ospr_pkg::chan_state_t nxt_state;
	logic [ospr_pkg::CUR_W-1:0] limit;
	logic                  drive;

	assign in_range = {1'b0, channel} < (CH_W + 1)'(NUM_CHANNELS);
	assign s1_adv   = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || s1_adv;
	assign accept   = in_valid && in_ready;
	assign mem_we   = s1_adv && inr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ospr_pkg::NUM_THR_REGS; i++) begin
				thr_q[i] <= ospr_pkg::DEF_THRESHOLD;
			end
			retry_delay_q <= ospr_pkg::DEF_RETRY_DELAY;
		end else if (wr_en) begin
			for (int i = 0; i < ospr_pkg::NUM_THR_REGS; i++) begin
				if (wr_index == ospr_pkg::IDX_W'(i)) begin
					thr_q[i] <= wr_data[ospr_pkg::CUR_W-1:0];
				end
			end
			if (wr_index == ospr_pkg::REG_RETRY_DELAY) begin
				retry_delay_q <= wr_data;
			end
		end
	end

	ospr_state_mem #(
		.DEPTH (NUM_CHANNELS),
		.AW    (AW)
	) u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_range),
		.rd_addr (channel[AW-1:0]),
		.rd_data (cur_state),
		.wr_en   (mem_we),
		.wr_addr (ch_s1[AW-1:0]),
		.wr_data (nxt_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1  <= channel;
			inr_s1 <= in_range;
			req_s1 <= switch_request;
			cur_s1 <= load_current;
		end
	end

	always_comb begin
		limit = ospr_pkg::DEF_THRESHOLD;
		for (int i = 0; i < ospr_pkg::NUM_THR_REGS; i++) begin
			if ({1'b0, ch_s1} == (CH_W + 1)'(i)) begin
				limit = thr_q[i];
			end
		end
	end

	always_comb begin
		nxt_state = cur_state;
		drive     = req_s1 && !cur_state.fault;
		if (drive) begin
			if (cur_s1 >= limit) begin
				nxt_state.status = cur_state.status | ospr_pkg::STAT_FAULT;
				nxt_state.fault  = 1'b1;
			end else begin
				nxt_state.status = ospr_pkg::STAT_ON_OK;
			end
		end else if (cur_state.fault) begin
			nxt_state.status = cur_state.status | ospr_pkg::STAT_FAULT;
		end else begin
			nxt_state.status = ospr_pkg::STAT_OFF;
		end

		if (nxt_state.fault) begin
			if (!cur_state.handled) begin
				nxt_state.delay   = retry_delay_q;
				nxt_state.handled = 1'b1;
			end else if (cur_state.delay != '0) begin
				nxt_state.delay = cur_state.delay - 1'b1;
			end else if (cur_state.retries >= ospr_pkg::MAX_RETRIES) begin
				nxt_state.retries = ospr_pkg::LATCHED_COUNT;
			end else begin
				nxt_state.retries = cur_state.retries + 1'b1;
				nxt_state.fault   = 1'b0;
				nxt_state.handled = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (inr_s1) begin
				drive_q   <= drive;
				status_q  <= nxt_state.status;
				latched_q <= (nxt_state.retries == ospr_pkg::LATCHED_COUNT);
				retries_q <= nxt_state.retries;
			end else begin
				drive_q   <= 1'b0;
				status_q  <= ospr_pkg::STAT_OFF;
				latched_q <= 1'b0;
				retries_q <= '0;
			end
		end
	end

	assign out_valid    = out_vld_q;
	assign drive_on     = drive_q;
	assign diag_status  = status_q;
	assign latched_off  = latched_q;
	assign retries_used = retries_q;

`ifndef ASSERT_OFF
	a_latched_not_driven: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && latched_off |-> !drive_on)
		else $error("latched channel reported as driven");

	a_on_ok_needs_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (diag_status == ospr_pkg::STAT_ON_OK) |-> drive_on)
		else $error("healthy status on an undriven channel");

	a_retries_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> retries_used <= ospr_pkg::LATCHED_COUNT)
		else $error("retry count beyond latch value");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s1 && out_vld_q && !out_ready)
		else $error("input stalled without a full pipeline");

	a_write_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> out_valid)
		else $error("state written without a result");
`endif

endmodule

[dv/output_short_protect_retry_tb.sv]
// ---------------------------------------------------------------------------
// Overcurrent protection with retry: block-level testbench
// Drives diagnostic ticks through the valid/ready input channel, with random
// gaps on the sender and random back-pressure on the result channel. A
// tracker class predicts each result from its own copy of the per-channel
// state and the threshold and delay registers. It compares every result
// transaction field by field in order. Several register settings are
// visited, including the extreme thresholds and retry delays.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module output_short_protect_retry_tb;

	localparam int CHANNELS       = ospr_pkg::DEF_NUM_CHANNELS;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;

	localparam logic [ospr_pkg::IDX_W-1:0] REG_THR_CH0  = 3'd0;
	localparam logic [ospr_pkg::IDX_W-1:0] REG_THR_CH1  = 3'd1;
	localparam logic [ospr_pkg::IDX_W-1:0] REG_THR_CH2  = 3'd2;
	localparam logic [ospr_pkg::IDX_W-1:0] REG_THR_CH3  = 3'd3;
	localparam logic [ospr_pkg::IDX_W-1:0] REG_THR_CH4  = 3'd4;
	localparam logic [ospr_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [ospr_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic                         drive;
		logic [ospr_pkg::STAT_W-1:0]  status;
		logic                         latched;
		logic [ospr_pkg::RETRY_W-1:0] retries;
	} tick_report_t;

	class ospr_tracker;
		logic [ospr_pkg::CUR_W-1:0]   limit [ospr_pkg::NUM_THR_REGS];
		logic [ospr_pkg::DELAY_W-1:0] reload;
		logic                         faulted [CHANNELS];
		logic                         handled [CHANNELS];
		logic [ospr_pkg::DELAY_W-1:0] countdown [CHANNELS];
		logic [ospr_pkg::RETRY_W-1:0] retries [CHANNELS];
		logic [ospr_pkg::STAT_W-1:0]  status [CHANNELS];
		tick_report_t                 due [$];
		int                           mismatches;

		function new();
			for (int i = 0; i < ospr_pkg::NUM_THR_REGS; i++)
				limit[i] = ospr_pkg::DEF_THRESHOLD;
			reload = ospr_pkg::DEF_RETRY_DELAY;
			for (int i = 0; i < CHANNELS; i++) begin
				faulted[i]   = 1'b0;
				handled[i]   = 1'b0;
				countdown[i] = '0;
				retries[i]   = '0;
				status[i]    = ospr_pkg::STAT_OFF;
			end
			mismatches = 0;
		endfunction

		function void set_reg(logic [ospr_pkg::IDX_W-1:0] idx,
				logic [ospr_pkg::DATA_W-1:0] data);
			if (idx < ospr_pkg::NUM_THR_REGS)
				limit[idx] = data[ospr_pkg::CUR_W-1:0];
			else if (idx == ospr_pkg::REG_RETRY_DELAY)
				reload = data;
		endfunction

		// Diagnosis first, then the retry sequencing on the same channel.
		function void note_tick(logic [2:0] ch, logic req,
				logic [ospr_pkg::CUR_W-1:0] cur);
			tick_report_t                r;
			logic [ospr_pkg::CUR_W-1:0]  lim;
			logic [ospr_pkg::STAT_W-1:0] st;
			r = '0;
			if (ch < CHANNELS) begin
				lim = (ch < ospr_pkg::NUM_THR_REGS) ? limit[ch] : ospr_pkg::DEF_THRESHOLD;
				r.drive = req && !faulted[ch];
				st = status[ch];
				if (r.drive) begin
					if (cur >= lim) begin
						st = st | ospr_pkg::STAT_FAULT;
						faulted[ch] = 1'b1;
					end else begin
						st = ospr_pkg::STAT_ON_OK;
					end
				end else if (faulted[ch]) begin
					st = st | ospr_pkg::STAT_FAULT;
				end else begin
					st = ospr_pkg::STAT_OFF;
				end
				status[ch] = st;
				if (faulted[ch]) begin
					if (!handled[ch]) begin
						countdown[ch] = reload;
						handled[ch] = 1'b1;
					end else if (countdown[ch] != '0) begin
						countdown[ch] = countdown[ch] - 1'b1;
					end else if (retries[ch] >= ospr_pkg::MAX_RETRIES) begin
						retries[ch] = ospr_pkg::LATCHED_COUNT;
					end else begin
						retries[ch] = retries[ch] + 1'b1;
						faulted[ch] = 1'b0;
						handled[ch] = 1'b0;
					end
				end
				r.status  = st;
				r.latched = (retries[ch] == ospr_pkg::LATCHED_COUNT);
				r.retries = retries[ch];
			end
			due.push_back(r);
		endfunction

		function void same_field(string name, logic [3:0] want, logic [3:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_report(tick_report_t got);
			tick_report_t want;
			if (due.size() == 0) begin
				$display({"%0t: result with nothing outstanding: drive_on %0d ",
					"diag_status %0d latched_off %0d retries_used %0d"},
					$time, got.drive, got.status, got.latched, got.retries);
				mismatches++;
				return;
			end
			want = due.pop_front();
			same_field("drive_on", 4'(want.drive), 4'(got.drive));
			same_field("diag_status", 4'(want.status), 4'(got.status));
			same_field("latched_off", 4'(want.latched), 4'(got.latched));
			same_field("retries_used", 4'(want.retries), 4'(got.retries));
		endfunction
	endclass

	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         in_valid       = 1'b0;
	logic                         in_ready;
	logic [2:0]                   channel        = '0;
	logic                         switch_request = 1'b0;
	logic [ospr_pkg::CUR_W-1:0]   load_current   = '0;
	logic                         out_valid;
	logic                         out_ready      = 1'b0;
	logic                         drive_on;
	logic [ospr_pkg::STAT_W-1:0]  diag_status;
	logic                         latched_off;
	logic [ospr_pkg::RETRY_W-1:0] retries_used;
	logic                         wr_en          = 1'b0;
	logic [ospr_pkg::IDX_W-1:0]   wr_index       = '0;
	logic [ospr_pkg::DATA_W-1:0]  wr_data        = '0;

	bit          no_gaps    = 1'b0;
	int          stall_left = 0;
	int          quiet      = 0;
	ospr_tracker sb         = new();

	output_short_protect_retry u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(negedge clk) begin
		if (stall_left == 0 && !no_gaps && $urandom_range(0, 3) == 0)
			stall_left = pick_gap();
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_report(tick_report_t'{drive_on, diag_status, latched_off, retries_used});
	end

	// The run is abandoned if no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet == WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_tick(input logic [2:0] ch, input logic req,
			input logic [ospr_pkg::CUR_W-1:0] cur);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		channel        <= ch;
		switch_request <= req;
		load_current   <= cur;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_tick(ch, req, cur);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ospr_pkg::IDX_W-1:0] idx,
			input logic [ospr_pkg::DATA_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	// Upper bits of the write data are junk for a threshold and must be dropped.
	task automatic set_limits(input int lo, input int hi);
		for (int i = 0; i < ospr_pkg::NUM_THR_REGS; i++)
			write_reg(REG_THR_CH0 + ospr_pkg::IDX_W'(i),
				{4'($urandom_range(0, 15)), 12'($urandom_range(lo, hi))});
	endtask

	task automatic random_ticks(input int n);
		logic [2:0]                 ch;
		logic                       req;
		logic [ospr_pkg::CUR_W-1:0] lim;
		logic [ospr_pkg::CUR_W-1:0] cur;
		repeat (n) begin
			if ($urandom_range(0, 99) < 8)
				ch = 3'($urandom_range(CHANNELS, 7));
			else
				ch = 3'($urandom_range(0, CHANNELS - 1));
			req = ($urandom_range(0, 3) != 0);
			lim = (ch < ospr_pkg::NUM_THR_REGS) ? sb.limit[ch] : ospr_pkg::DEF_THRESHOLD;
			if (lim == '0 || $urandom_range(0, 99) < 6)
				cur = 12'($urandom_range(lim, 4095));
			else
				cur = 12'($urandom_range(0, lim - 1));
			send_tick(ch, req, cur);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values: threshold 40 on every channel, retry delay 100.
		send_tick(3'd0, 1'b1, 12'd0);
		send_tick(3'd0, 1'b1, 12'd39);
		send_tick(3'd0, 1'b0, 12'hFFF);
		send_tick(3'd1, 1'b1, 12'd40);
		send_tick(3'd1, 1'b1, 12'd0);
		send_tick(3'd1, 1'b0, 12'd0);
		send_tick(3'd2, 1'b1, 12'hFFF);
		send_tick(3'd5, 1'b1, 12'hFFF);
		send_tick(3'd6, 1'b0, 12'hAAA);
		send_tick(3'd7, 1'b1, 12'h555);
		settle();

		write_reg(ospr_pkg::REG_RETRY_DELAY, 16'd0);
		write_reg(REG_THR_CH3, 16'h0FFF);
		write_reg(REG_THR_CH4, 16'hF000);
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h5A5A);

		send_tick(3'd3, 1'b1, 12'hFFE);
		send_tick(3'd3, 1'b1, 12'hFFF);
		send_tick(3'd3, 1'b1, 12'd0);
		send_tick(3'd3, 1'b1, 12'd0);
		send_tick(3'd4, 1'b0, 12'd0);
		// A zero threshold faults on every drive, so channel 4 walks to latch-off.
		repeat (9) send_tick(3'd4, 1'b1, 12'd0);
		settle();

		write_reg(ospr_pkg::REG_RETRY_DELAY, 16'd2);
		set_limits(200, 3800);
		random_ticks(120);
		settle();

		no_gaps = 1'b1;
		write_reg(ospr_pkg::REG_RETRY_DELAY, 16'd0);
		set_limits(1, 4095);
		random_ticks(50);
		settle();
		random_ticks(50);
		settle();
		no_gaps = 1'b0;

		write_reg(ospr_pkg::REG_RETRY_DELAY, 16'd7);
		set_limits(100, 4000);
		random_ticks(100);
		settle();

		write_reg(ospr_pkg::REG_RETRY_DELAY, 16'd1);
		set_limits(50, 3000);
		write_reg(REG_THR_CH0, 16'h0FFF);
		random_ticks(100);
		settle();

		write_reg(ospr_pkg::REG_RETRY_DELAY, 16'hFFFF);
		set_limits(1, 4095);
		write_reg(REG_THR_CH1, 16'h0000);
		write_reg(REG_THR_CH2, 16'hFFFF);
		random_ticks(80);
		settle();

		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
